// ===== src/mf9_pkg.sv =====
// ============================================================================
// mf9_pkg
// Shared types and constants for the 9-bit minifloat arithmetic unit.
// ============================================================================
package mf9_pkg;

    localparam int EXP_WIDTH  = 3;
    localparam int FRAC_WIDTH = 5;
    localparam int WORD_WIDTH = 1 + EXP_WIDTH + FRAC_WIDTH;
    localparam int MAG_WIDTH  = 12;  // finite magnitudes in units of 2^-7, sum fits
    localparam int PROD_SHIFT = 7;   // bias - 1 + fraction width

    localparam logic [EXP_WIDTH-1:0]  EXP_TOP   = '1;
    localparam logic [WORD_WIDTH-1:0] POS_INF   = 9'h0E0;
    localparam logic [WORD_WIDTH-1:0] QNAN      = 9'h0FF;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_NEG = 2'd3
    } cmd_t;

endpackage

// ===== src/minifloat9_add_sub_mul_unit.sv =====
// ============================================================================
// minifloat9_add_sub_mul_unit
// Add, subtract, multiply and negate on a 1-3-5 minifloat with denormals.
// ============================================================================
// Usage:
//   Input channel: valid/ready with command, operand_a, operand_b. Output
//   channel: valid/ready with result. One result per input transfer.
//   The operands are captured in an input register; one pass of
//   combinational logic (unpack, add or 11x11 multiply, leading-one search
//   over 12 bits, pack) feeds the result register.
//   Throughput: one item per cycle while the receiver takes results. Each
//   register stage advances whenever the stage after it is empty or being
//   drained, so a stalled receiver backs up the pipeline and in_ready falls
//   only when both stages hold data.
//   Reset clears both stage valid flags; payload registers are not reset.
//   The result is the exact value truncated toward zero; overflow gives
//   signed infinity; NaN from add, subtract or multiply is 0x0FF.
// ============================================================================
module minifloat9_add_sub_mul_unit #(
    parameter int EXP_WIDTH  = mf9_pkg::EXP_WIDTH,
    parameter int FRAC_WIDTH = mf9_pkg::FRAC_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [EXP_WIDTH+FRAC_WIDTH:0] operand_a,
    input  logic [EXP_WIDTH+FRAC_WIDTH:0] operand_b,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [EXP_WIDTH+FRAC_WIDTH:0] result
);
    localparam int W = EXP_WIDTH + FRAC_WIDTH + 1;
    localparam int M = mf9_pkg::MAG_WIDTH;

    logic         s1_valid_reg;
    logic [1:0]   cmd_reg;
    logic [W-1:0] a_reg, b_reg;
    logic         out_valid_reg;
    logic [W-1:0] result_reg, result_next;
    logic         s1_adv, s2_adv;

    // Advance output stage when empty or drained
    assign s2_adv   = !out_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= in_valid;
            if (s2_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            cmd_reg <= command;
            a_reg   <= operand_a;
            b_reg   <= operand_b;
        end
        if (s2_adv && s1_valid_reg)
            result_reg <= result_next;
    end

    // Unpack a word into its magnitude in units of 2^-7; infinities and NaNs give zero
    function automatic logic [M-1:0] mag_of(input logic [W-1:0] w);
        logic [EXP_WIDTH-1:0] e;
        logic [M-1:0]         m;
        e = w[W-2:FRAC_WIDTH];
        m = '0;
        if (e == '0)
            m = M'(w[FRAC_WIDTH-1:0]);
        else if (e != mf9_pkg::EXP_TOP)
            m = M'({1'b1, w[FRAC_WIDTH-1:0]}) << (e - 1'b1);
        return m;
    endfunction

    // Truncate a magnitude into the format
    function automatic logic [W-1:0] pack(input logic neg, input logic [M-1:0] mag);
        logic [3:0]   p;
        logic [3:0]   e;
        logic [W-1:0] r;
        p = '0;
        for (int i = 0; i < M; i++)
            if (mag[i])
                p = 4'(i);
        if (mag < M'(1 << FRAC_WIDTH))
            r = {neg, (W-1)'(mag)};
        else
        begin
            e = p - 4'(FRAC_WIDTH) + 4'd1;
            if (e >= 4'(mf9_pkg::EXP_TOP))
                r = {neg, mf9_pkg::POS_INF[W-2:0]};
            else
                r = {neg, e[EXP_WIDTH-1:0],
                     FRAC_WIDTH'(mag >> (p - 4'(FRAC_WIDTH)))};
        end
        return r;
    endfunction

    // Compute the result from the input register
    always_comb
    begin
        logic [W-1:0]  bb;
        logic          a_nan, b_nan, a_inf, b_inf, an, bn, sx;
        logic [M-1:0]  am, bm;
        logic [21:0]   prod;
        logic [M-1:0]  prod_mag;
        bb    = (cmd_reg == mf9_pkg::CMD_SUB) ? (b_reg ^ W'(1 << (W - 1))) : b_reg;
        a_nan = (a_reg[W-2:FRAC_WIDTH] == mf9_pkg::EXP_TOP) && (a_reg[FRAC_WIDTH-1:0] != '0);
        b_nan = (bb[W-2:FRAC_WIDTH] == mf9_pkg::EXP_TOP) && (bb[FRAC_WIDTH-1:0] != '0);
        a_inf = (a_reg[W-2:FRAC_WIDTH] == mf9_pkg::EXP_TOP) && (a_reg[FRAC_WIDTH-1:0] == '0);
        b_inf = (bb[W-2:FRAC_WIDTH] == mf9_pkg::EXP_TOP) && (bb[FRAC_WIDTH-1:0] == '0);
        an    = a_reg[W-1];
        bn    = bb[W-1];
        sx    = an ^ bn;
        am    = mag_of(a_reg);
        bm    = mag_of(bb);
        prod  = 22'(am[10:0] * bm[10:0]);
        // Clamp oversized products; anything at or above 2^11 packs to infinity
        prod_mag = (|prod[21:19]) ? {M{1'b1}} : prod[18:7];
        result_next = '0;
        unique case (mf9_pkg::cmd_t'(cmd_reg))
            mf9_pkg::CMD_ADD, mf9_pkg::CMD_SUB:
            begin
                if (a_nan || b_nan)
                    result_next = mf9_pkg::QNAN;
                else if (a_inf && b_inf)
                    result_next = (an != bn) ? mf9_pkg::QNAN
                                             : {an, mf9_pkg::POS_INF[W-2:0]};
                else if (a_inf)
                    result_next = {an, mf9_pkg::POS_INF[W-2:0]};
                else if (b_inf)
                    result_next = {bn, mf9_pkg::POS_INF[W-2:0]};
                else if (am == bm && an != bn)
                    result_next = '0;
                else if (am == '0 && bm == '0)
                    result_next = {an & bn, {(W-1){1'b0}}};
                else if (an == bn)
                    result_next = pack(an, am + bm);
                else if (am > bm)
                    result_next = pack(an, am - bm);
                else
                    result_next = pack(bn, bm - am);
            end
            mf9_pkg::CMD_MUL:
            begin
                if (a_nan || b_nan)
                    result_next = mf9_pkg::QNAN;
                else if (a_inf || b_inf)
                    result_next = ((!a_inf && am == '0) || (!b_inf && bm == '0))
                                  ? mf9_pkg::QNAN : {sx, mf9_pkg::POS_INF[W-2:0]};
                else if (am == '0 || bm == '0)
                    result_next = '0;
                else
                    result_next = pack(sx, prod_mag);
            end
            mf9_pkg::CMD_NEG:
                result_next = a_reg ^ W'(1 << (W - 1));
            default:
                result_next = '0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Checks
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (!out_valid || out_ready) |=> out_valid)
        else $error("stage 1 item lost");

endmodule

// ===== bench/minifloat9_add_sub_mul_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Minifloat9 arithmetic unit testbench
// Feeds add, subtract, multiply and negate commands through the valid/ready
// input channel and checks every result against a behavioural predictor of
// the 1-3-5 format, under several phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module minifloat9_add_sub_mul_unit_tb;

    typedef struct packed {
        mf9_pkg::cmd_t op;
        logic [8:0]    a;
        logic [8:0]    b;
    } mf_item_t;

    typedef struct {
        logic       neg;
        logic       is_nan;
        logic       is_inf;
        int unsigned mag;
    } mf_val_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [8:0] operand_a;
    logic [8:0] operand_b;
    logic       out_valid;
    logic       out_ready;
    logic [8:0] result;
    logic       in_ready_seen;

    mf_item_t    pending_items[$];
    logic [8:0]  expected_results[$];
    int          error_count;
    int          transfers_in;
    int          transfers_out;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          op_count[4];

    minifloat9_add_sub_mul_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // Clock generation
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Split a word into sign, class and exact magnitude in units of 2^-7
    function automatic mf_val_t decode_word(input logic [8:0] w);
        mf_val_t    v;
        logic [2:0] e;
        logic [4:0] f;
        e = w[7:5];
        f = w[4:0];
        v.neg    = w[8];
        v.is_nan = (e == mf9_pkg::EXP_TOP) && (f != 0);
        v.is_inf = (e == mf9_pkg::EXP_TOP) && (f == 0);
        v.mag    = 0;
        if (e == 0)
            v.mag = f;
        else if (e != mf9_pkg::EXP_TOP)
            v.mag = ({26'd0, 1'b1, f}) << (e - 1);
        return v;
    endfunction

    // Truncate a magnitude into the format
    function automatic logic [8:0] encode_mag(input logic neg, input int unsigned mag);
        int unsigned msb;
        int unsigned ex;
        if (mag < 32)
            return {neg, mag[7:0]};
        msb = 0;
        for (int i = 0; i < 32; i++)
            if (mag[i])
                msb = i;
        ex = msb - 4;
        if (ex >= 7)
            return {neg, mf9_pkg::POS_INF[7:0]};
        return {neg, ex[2:0], 5'((mag >> (msb - 5)) & 32'h1F)};
    endfunction

    function automatic logic [8:0] predict_sum(input logic [8:0] wa, input logic [8:0] wb);
        mf_val_t x;
        mf_val_t y;
        x = decode_word(wa);
        y = decode_word(wb);
        if (x.is_nan || y.is_nan)
            return mf9_pkg::QNAN;
        if (x.is_inf && y.is_inf)
            return (x.neg != y.neg) ? mf9_pkg::QNAN : {x.neg, mf9_pkg::POS_INF[7:0]};
        if (x.is_inf)
            return {x.neg, mf9_pkg::POS_INF[7:0]};
        if (y.is_inf)
            return {y.neg, mf9_pkg::POS_INF[7:0]};
        if (x.mag == y.mag && x.neg != y.neg)
            return 9'd0;
        if (x.mag == 0 && y.mag == 0)
            return {x.neg & y.neg, 8'd0};
        if (x.neg == y.neg)
            return encode_mag(x.neg, x.mag + y.mag);
        if (x.mag > y.mag)
            return encode_mag(x.neg, x.mag - y.mag);
        return encode_mag(y.neg, y.mag - x.mag);
    endfunction

    function automatic logic [8:0] predict_product(input logic [8:0] wa, input logic [8:0] wb);
        mf_val_t x;
        mf_val_t y;
        logic    sx;
        x = decode_word(wa);
        y = decode_word(wb);
        sx = x.neg ^ y.neg;
        if (x.is_nan || y.is_nan)
            return mf9_pkg::QNAN;
        if (x.is_inf || y.is_inf)
        begin
            if ((!x.is_inf && x.mag == 0) || (!y.is_inf && y.mag == 0))
                return mf9_pkg::QNAN;
            return {sx, mf9_pkg::POS_INF[7:0]};
        end
        if (x.mag == 0 || y.mag == 0)
            return 9'd0;
        return encode_mag(sx, (x.mag * y.mag) >> mf9_pkg::PROD_SHIFT);
    endfunction

    function automatic logic [8:0] predict_result(input mf_item_t it);
        case (it.op)
            mf9_pkg::CMD_ADD: return predict_sum(it.a, it.b);
            mf9_pkg::CMD_SUB: return predict_sum(it.a, it.b ^ 9'h100);
            mf9_pkg::CMD_MUL: return predict_product(it.a, it.b);
            default: return it.a ^ 9'h100;
        endcase
    endfunction

    // Pick an operand, biased towards zeros, infinities, NaNs and boundaries
    function automatic logic [8:0] pick_operand();
        logic [8:0] w;
        w = 9'($urandom_range(0, 511));
        case ($urandom_range(0, 9))
            0: w[7:0] = 8'd0;
            1: w[7:0] = mf9_pkg::POS_INF[7:0];
            2: w[7:0] = {3'd7, 5'($urandom_range(1, 31))};
            3: w[7:5] = 3'd0;
            4: w[7:5] = 3'd6;
            default: ;
        endcase
        return w;
    endfunction

    // Driver: present queued items, hold until transferred
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            command   <= mf9_pkg::CMD_ADD;
            operand_a <= '0;
            operand_b <= '0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (pending_items.size() > 0 && $urandom_range(1, 100) > send_idle_pct)
            begin
                mf_item_t it;
                it = pending_items.pop_front();
                in_valid  <= 1'b1;
                command   <= it.op;
                operand_a <= it.a;
                operand_b <= it.b;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Record whether the last rising edge completed an input transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_seen <= 1'b0;
        else
        begin
            in_ready_seen <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                mf_item_t it;
                it.op = mf9_pkg::cmd_t'(command);
                it.a  = operand_a;
                it.b  = operand_b;
                expected_results.push_back(predict_result(it));
                op_count[command]++;
                transfers_in++;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            transfers_out++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                error_count++;
            end
            else
            begin
                logic [8:0] want;
                want = expected_results.pop_front();
                if (result !== want)
                begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, want, result);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_item(input mf9_pkg::cmd_t op, input logic [8:0] a,
                              input logic [8:0] b);
        mf_item_t it;
        it.op = op;
        it.a  = a;
        it.b  = b;
        pending_items.push_back(it);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            queue_item(mf9_pkg::cmd_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
        while (pending_items.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        rst_n          = 1'b0;
        error_count    = 0;
        transfers_in   = 0;
        transfers_out  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes and special cases
        queue_item(mf9_pkg::CMD_ADD, 9'h0FF, 9'h020);   // NaN propagates
        queue_item(mf9_pkg::CMD_MUL, 9'h020, 9'h1E5);   // negative-signed NaN
        queue_item(mf9_pkg::CMD_ADD, 9'h0E0, 9'h1E0);   // inf - inf
        queue_item(mf9_pkg::CMD_SUB, 9'h0E0, 9'h0E0);   // inf - inf via subtract
        queue_item(mf9_pkg::CMD_ADD, 9'h1E0, 9'h0C0);   // inf dominates
        queue_item(mf9_pkg::CMD_ADD, 9'h040, 9'h1E0);
        queue_item(mf9_pkg::CMD_MUL, 9'h0E0, 9'h100);   // inf times zero
        queue_item(mf9_pkg::CMD_MUL, 9'h1E0, 9'h041);   // inf times finite
        queue_item(mf9_pkg::CMD_SUB, 9'h0A3, 9'h0A3);   // x - x
        queue_item(mf9_pkg::CMD_ADD, 9'h100, 9'h100);   // -0 + -0
        queue_item(mf9_pkg::CMD_ADD, 9'h100, 9'h000);
        queue_item(mf9_pkg::CMD_MUL, 9'h000, 9'h1DF);   // zero times x
        queue_item(mf9_pkg::CMD_MUL, 9'h101, 9'h001);   // underflow keeps sign
        queue_item(mf9_pkg::CMD_ADD, 9'h0DF, 9'h0DF);   // overflow
        queue_item(mf9_pkg::CMD_MUL, 9'h1DF, 9'h0DF);
        queue_item(mf9_pkg::CMD_ADD, 9'h01F, 9'h001);   // denormal to normal
        queue_item(mf9_pkg::CMD_SUB, 9'h020, 9'h001);   // normal to denormal
        queue_item(mf9_pkg::CMD_SUB, 9'h001, 9'h005);   // negative denormal
        queue_item(mf9_pkg::CMD_NEG, 9'h0FF, 9'h1FF);
        queue_item(mf9_pkg::CMD_NEG, 9'h1E0, 9'h000);
        queue_item(mf9_pkg::CMD_NEG, 9'h000, 9'h0AA);
        queue_item(mf9_pkg::CMD_ADD, 9'h1FF, 9'h1FF);
        queue_item(mf9_pkg::CMD_MUL, 9'h0C5, 9'h0C5);
        run_phase(0, 0, 0);

        run_phase(0, 0, 200);
        run_phase(55, 0, 200);
        run_phase(0, 55, 200);
        run_phase(21, 21, 200);
        repeat (10) @(posedge clk);

        $display("Covered %0d transfers (add %0d, sub %0d, mul %0d, neg %0d), %0d results",
                 transfers_in, op_count[0], op_count[1], op_count[2], op_count[3],
                 transfers_out);
        if (error_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Run-time limit
    initial
    begin
        #2000000;
        $display("Timed out");
        $display("status: fail");
        $finish;
    end

endmodule

// ===== minifloat9_add_sub_mul_unit.f =====
src/mf9_pkg.sv
src/minifloat9_add_sub_mul_unit.sv
bench/minifloat9_add_sub_mul_unit_tb.sv
